// ----- rtl/core/vertex_transform_engine_top_assert.svh -----
// Assertion macros for the vertex transform engine checker.
`ifndef VERTEX_TRANSFORM_ENGINE_TOP_ASSERT_SVH
`define VERTEX_TRANSFORM_ENGINE_TOP_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define VTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform engine: next-cycle check failed");

// Antecedent implies the consequent in the same cycle.
`define VTE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform engine: same-cycle check failed");

`endif

// ----- rtl/core/vte_pkg.sv -----
// Shared types, codes and a helper function of the vertex transform engine.
`timescale 1ns / 1ps
package vte_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic [2:0] REQ_VERTEX    = 3'd0;
    localparam logic [2:0] REQ_TRANSLATE = 3'd1;
    localparam logic [2:0] REQ_ROTATE    = 3'd2;
    localparam logic [2:0] REQ_SCALE     = 3'd3;
    localparam logic [2:0] REQ_MIRROR    = 3'd4;
    localparam logic [2:0] REQ_IDENTITY  = 3'd5;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_Z_TO_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_Z_TO_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEP_COS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEP_SIN = 3'd3;

    localparam logic signed [31:0] PROJ_Z_TO_X_RST  = -32'sd17212;
    localparam logic signed [31:0] PROJ_Z_TO_Y_RST  = -32'sd27880;
    localparam logic signed [17:0] ROT_STEP_COS_RST = 18'sd64540;
    localparam logic signed [17:0] ROT_STEP_SIN_RST = 18'sd11380;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         axis_sel;
        logic               turn_negative;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] homog_w;
    } out_word_t;

    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic [1:0] dst;
    } mac_ctl_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] dst;
    } mac_res_t;

    // Entry (k, j) of the operator matrix that a command post-multiplies by.
    function automatic logic signed [32:0] b_elem(
        input logic [2:0]         req,
        input logic [1:0]         axis,
        input logic               neg,
        input logic signed [31:0] vx,
        input logic signed [31:0] vy,
        input logic signed [31:0] vz,
        input logic signed [17:0] c,
        input logic signed [17:0] s_raw,
        input logic [1:0]         k,
        input logic [1:0]         j,
        input logic signed [32:0] one
    );
        logic signed [32:0] c_e;
        logic signed [32:0] s_e;
        logic signed [32:0] r;
        logic [3:0]         idx;
        c_e = 33'(c);
        s_e = neg ? -33'(s_raw) : 33'(s_raw);
        idx = {k, j};
        r   = (k == j) ? one : '0;
        case (req)
            REQ_TRANSLATE:
            begin
                if (idx == 4'd12) r = 33'(vx);
                if (idx == 4'd13) r = 33'(vy);
                if (idx == 4'd14) r = 33'(vz);
            end
            REQ_SCALE:
            begin
                if (idx == 4'd0)  r = 33'(vx);
                if (idx == 4'd5)  r = 33'(vy);
                if (idx == 4'd10) r = 33'(vz);
            end
            REQ_ROTATE:
            begin
                case (axis)
                    AXIS_X:
                    begin
                        if (idx == 4'd5 || idx == 4'd10) r = c_e;
                        if (idx == 4'd6) r = s_e;
                        if (idx == 4'd9) r = -s_e;
                    end
                    AXIS_Y:
                    begin
                        if (idx == 4'd0 || idx == 4'd10) r = c_e;
                        if (idx == 4'd2) r = -s_e;
                        if (idx == 4'd8) r = s_e;
                    end
                    AXIS_Z:
                    begin
                        if (idx == 4'd0 || idx == 4'd5) r = c_e;
                        if (idx == 4'd1) r = s_e;
                        if (idx == 4'd4) r = -s_e;
                    end
                    default: r = r;
                endcase
            end
            REQ_MIRROR:
            begin
                case (axis)
                    AXIS_X:  if (idx == 4'd10) r = -one;
                    AXIS_Y:  if (idx == 4'd0)  r = -one;
                    AXIS_Z:  if (idx == 4'd5)  r = -one;
                    default: r = r;
                endcase
            end
            default: r = r;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/vte_mac.sv -----
// Shared multiply-accumulate unit: one registered product, floor shift, saturating sum.
`timescale 1ns / 1ps
module vte_mac #(
    parameter int FRAC_BITS = vte_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vte_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0] op_a,
    input  logic signed [32:0] op_b,
    input  logic signed [31:0] init,
    output vte_pkg::mac_res_t  res,
    output logic signed [31:0] res_data
);
    import vte_pkg::*;

    localparam int PROD_W = 65;
    localparam int ACC_W  = 68;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd2147483648);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       init_reg;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] shifted;
    logic signed [31:0]       sat_val;
    mac_res_t                 res_reg;
    logic signed [31:0]       res_data_reg;

    // Arithmetic shift of a signed product rounds toward minus infinity.
    assign shifted  = prod_reg >>> FRAC_BITS;
    assign acc_next = (ctl_reg.first ? ACC_W'(init_reg) : acc_reg) + ACC_W'(shifted);

    always_comb
    begin
        if (acc_next > SAT_HI)
            sat_val = 32'sh7FFF_FFFF;
        else if (acc_next < SAT_LO)
            sat_val = 32'sh8000_0000;
        else
            sat_val = acc_next[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            ctl_reg       <= ctl;
            res_reg.valid <= ctl_reg.issue && ctl_reg.last;
            res_reg.dst   <= ctl_reg.dst;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        init_reg <= init;
        if (ctl_reg.issue)
            acc_reg <= acc_next;
        if (ctl_reg.issue && ctl_reg.last)
            res_data_reg <= sat_val;
    end

    assign res      = res_reg;
    assign res_data = res_data_reg;

endmodule

// ----- rtl/core/vertex_transform_engine_top.sv -----
// Top level of the vertex transform engine: matrix store, sequencer and result register.
`timescale 1ns / 1ps
// The block holds a 4x4 row-vector transform matrix in fixed point, identity after reset.
// Input words arrive on in_valid/in_ready with an in_word payload; a word is taken at a
// rising edge where both are high. Command words (translate, rotate, scale, mirror)
// post-multiply the matrix; an identity word restores it while idle; unused codes and
// a rotate or mirror with axis selector three are dropped without effect.
// A vertex word is transformed and projected and yields one out_word on out_valid/out_ready.
// Every product runs through one shared multiplier followed by an accumulator, so the cost
// is set by the number of products: a vertex issues 16 products, lets the pipeline drain,
// issues the two projection products and drains again before the result register is
// loaded. A matrix command issues 64 products (four per entry) and then drains.
// in_ready is high only while the sequencer is idle.
// The result register holds a finished word while the receiver stalls; the sequencer is
// idle again as soon as the word is loaded, so the next input is taken meanwhile. A second
// vertex waits in its final step until the held word is taken.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata are taken at once and are meant only
// while the block is idle. Reset restores the identity matrix and config defaults.
module vertex_transform_engine_top #(
    parameter int FRAC_BITS = vte_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  vte_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vte_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [vte_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [31:0]                      cfg_wdata
);
    import vte_pkg::*;

    localparam logic signed [31:0] ONE    = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [32:0] ONE_33 = 33'(ONE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMD   = 3'd1;
    localparam logic [2:0] ST_CWAIT = 3'd2;
    localparam logic [2:0] ST_VTX   = 3'd3;
    localparam logic [2:0] ST_VWAIT = 3'd4;
    localparam logic [2:0] ST_PROJ  = 3'd5;
    localparam logic [2:0] ST_PWAIT = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         wr_row_reg, wr_row_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;
    in_word_t           cmd_reg, cmd_next;
    logic signed [31:0] mat_reg [16];
    logic signed [31:0] mat_next [16];
    logic signed [31:0] row_reg [4];
    logic signed [31:0] row_next [4];
    logic signed [31:0] t_reg [4];
    logic signed [31:0] t_next [4];
    logic signed [31:0] pzx_reg, pzy_reg;
    logic signed [17:0] cos_reg, sin_reg;

    mac_ctl_t           mac_ctl;
    mac_res_t           mac_res;
    logic signed [31:0] mac_a;
    logic signed [32:0] mac_b;
    logic signed [31:0] mac_init;
    logic signed [31:0] mac_data;

    logic [1:0] idx_i, idx_j, idx_k;
    logic [1:0] v_col, v_row;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign idx_i = cnt_reg[5:4];
    assign idx_j = cnt_reg[3:2];
    assign idx_k = cnt_reg[1:0];
    assign v_col = cnt_reg[3:2];
    assign v_row = cnt_reg[1:0];

    vte_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .op_a     (mac_a),
        .op_b     (mac_b),
        .init     (mac_init),
        .res      (mac_res),
        .res_data (mac_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wr_row_next    = wr_row_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        cmd_next       = cmd_reg;
        mat_next       = mat_reg;
        row_next       = row_reg;
        t_next         = t_reg;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;
        mac_init       = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // Results land in the vertex buffer or in the row buffer of a command.
        // The last entry of a row commits the whole row to the matrix.
        if (mac_res.valid)
        begin
            if (state_reg == ST_CMD || state_reg == ST_CWAIT)
            begin
                row_next[mac_res.dst] = mac_data;
                if (mac_res.dst == 2'd3)
                begin
                    mat_next[{wr_row_reg, 2'd0}] = row_reg[0];
                    mat_next[{wr_row_reg, 2'd1}] = row_reg[1];
                    mat_next[{wr_row_reg, 2'd2}] = row_reg[2];
                    mat_next[{wr_row_reg, 2'd3}] = mac_data;
                    wr_row_next                  = wr_row_reg + 2'd1;
                end
            end
            else
            begin
                t_next[mac_res.dst] = mac_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_word;
                    cnt_next    = '0;
                    wr_row_next = '0;
                    case (in_word.req_type)
                        REQ_VERTEX:
                            state_next = ST_VTX;
                        REQ_TRANSLATE, REQ_SCALE:
                            state_next = ST_CMD;
                        REQ_ROTATE, REQ_MIRROR:
                            if (in_word.axis_sel != AXIS_NONE)
                                state_next = ST_CMD;
                        REQ_IDENTITY:
                            for (int n = 0; n < 16; n++)
                                mat_next[n] = ((n % 5) == 0) ? ONE : '0;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CMD:
            begin
                mac_ctl.issue = 1'b1;
                mac_ctl.first = (idx_k == 2'd0);
                mac_ctl.last  = (idx_k == 2'd3);
                mac_ctl.dst   = idx_j;
                mac_a         = mat_reg[{idx_i, idx_k}];
                mac_b         = b_elem(cmd_reg.req_type, cmd_reg.axis_sel,
                                       cmd_reg.turn_negative, cmd_reg.val_x,
                                       cmd_reg.val_y, cmd_reg.val_z, cos_reg,
                                       sin_reg, idx_k, idx_j, ONE_33);
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (mac_res.valid && mac_res.dst == 2'd3 && wr_row_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            ST_VTX:
            begin
                mac_ctl.issue = 1'b1;
                mac_ctl.first = (v_row == 2'd0);
                mac_ctl.last  = (v_row == 2'd3);
                mac_ctl.dst   = v_col;
                mac_a         = mat_reg[{v_row, v_col}];
                case (v_row)
                    2'd0:    mac_b = 33'(cmd_reg.val_x);
                    2'd1:    mac_b = 33'(cmd_reg.val_y);
                    2'd2:    mac_b = 33'(cmd_reg.val_z);
                    default: mac_b = ONE_33;
                endcase
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_VWAIT;
                end
            end
            ST_VWAIT:
            begin
                if (mac_res.valid && mac_res.dst == 2'd3)
                    state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                // Depth times the projection weight, added to transformed x or y.
                mac_ctl.issue = 1'b1;
                mac_ctl.first = 1'b1;
                mac_ctl.last  = 1'b1;
                mac_ctl.dst   = {1'b0, cnt_reg[0]};
                mac_a         = t_reg[2];
                mac_b         = cnt_reg[0] ? 33'(pzy_reg) : 33'(pzx_reg);
                mac_init      = t_reg[{1'b0, cnt_reg[0]}];
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg[0])
                    state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (mac_res.valid && mac_res.dst == 2'd1)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.screen_x = t_reg[0];
                    out_word_next.screen_y = t_reg[1];
                    out_word_next.homog_w  = t_reg[3];
                    state_next             = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            wr_row_reg    <= '0;
            out_valid_reg <= 1'b0;
            pzx_reg       <= PROJ_Z_TO_X_RST;
            pzy_reg       <= PROJ_Z_TO_Y_RST;
            cos_reg       <= ROT_STEP_COS_RST;
            sin_reg       <= ROT_STEP_SIN_RST;
            for (int n = 0; n < 16; n++)
                mat_reg[n] <= ((n % 5) == 0) ? ONE : '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wr_row_reg    <= wr_row_next;
            out_valid_reg <= out_valid_next;
            mat_reg       <= mat_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_PROJ_Z_TO_X:  pzx_reg <= cfg_wdata;
                    CFG_PROJ_Z_TO_Y:  pzy_reg <= cfg_wdata;
                    CFG_ROT_STEP_COS: cos_reg <= cfg_wdata[17:0];
                    CFG_ROT_STEP_SIN: sin_reg <= cfg_wdata[17:0];
                    default:          pzx_reg <= pzx_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        cmd_reg      <= cmd_next;
        row_reg      <= row_next;
        t_reg        <= t_next;
    end

endmodule

// ----- rtl/core/vte_checker.sv -----
// Port-level checker of the vertex transform engine and its bind statement.
`timescale 1ns / 1ps
`include "vertex_transform_engine_top_assert.svh"
module vte_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input vte_pkg::in_word_t   in_word,
    input logic                out_valid,
    input logic                out_ready,
    input vte_pkg::out_word_t  out_word
);
    import vte_pkg::*;

    logic vtx_take;
    logic cmd_take;

    assign vtx_take = in_valid && in_ready && (in_word.req_type == REQ_VERTEX);
    assign cmd_take = in_valid && in_ready &&
                      (in_word.req_type == REQ_TRANSLATE || in_word.req_type == REQ_SCALE);

    // A stalled result word stays put.
    `VTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
    // A vertex word keeps the sequencer busy in the following cycle.
    `VTE_ASSERT_NEXT(a_vtx_busy, vtx_take, !in_ready)
    // Translate and scale always run the matrix product.
    `VTE_ASSERT_NEXT(a_cmd_busy, cmd_take, !in_ready)
    // A new result word only follows busy work.
    `VTE_ASSERT_SAME(a_out_from_work, $rose(out_valid), $past(!in_ready))

endmodule

bind vertex_transform_engine_top vte_checker u_vte_checker (.*);
